[rtl/frs_pkg.sv]
package frs_pkg;

   // Fixed settings for the still-mode upright test
   localparam logic signed [15:0] STILL_GRAVITY_LIMIT = -16'sd15581;
   localparam logic [31:0]        STILL_HOLD_US       = 32'd300000;

   // Register reset values
   localparam logic signed [15:0] FALLEN_GRAVITY_LIMIT_RST  = 16'sd0;
   localparam logic [31:0]        FALLEN_DEBOUNCE_TIME_RST  = 32'd200000;
   localparam logic [31:0]        STUCK_TIME_RST            = 32'd0;
   localparam logic signed [15:0] STUCK_GRAVITY_LIMIT_RST   = 16'sd0;
   localparam logic signed [15:0] UPRIGHT_GRAVITY_LIMIT_RST = -16'sd15581;
   localparam logic [31:0]        UPRIGHT_HOLD_TIME_RST     = 32'd200000;
   localparam logic [15:0]        STILL_GYRO_LIMIT_RST      = 16'd0;
   localparam logic [31:0]        GIVE_UP_TIME_RST          = 32'd5000000;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FALLEN_GRAVITY_LIMIT  = 3'd0,
      CSR_FALLEN_DEBOUNCE_TIME  = 3'd1,
      CSR_STUCK_TIME            = 3'd2,
      CSR_STUCK_GRAVITY_LIMIT   = 3'd3,
      CSR_UPRIGHT_GRAVITY_LIMIT = 3'd4,
      CSR_UPRIGHT_HOLD_TIME     = 3'd5,
      CSR_STILL_GYRO_LIMIT      = 3'd6,
      CSR_GIVE_UP_TIME          = 3'd7
   } frs_csr_index_type;

   typedef enum logic {
      MODE_NORMAL   = 1'b0,
      MODE_RECOVERY = 1'b1
   } frs_mode_type;

   typedef struct packed {
      logic signed [15:0] fallen_gravity_limit;
      logic [31:0]        fallen_debounce_time;
      logic [31:0]        stuck_time;
      logic signed [15:0] stuck_gravity_limit;
      logic signed [15:0] upright_gravity_limit;
      logic [31:0]        upright_hold_time;
      logic [15:0]        still_gyro_limit;
      logic [31:0]        give_up_time;
   } frs_cfg_type;

   typedef struct packed {
      logic signed [15:0] gravity_z;
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_z;
      logic [15:0]        tick_time;
   } frs_sample_type;

   typedef struct packed {
      logic        active_driver;
      logic        handed_off;
      logic        handed_back;
      logic [31:0] rescue_count;
      logic [31:0] stuck_rescue_count;
      logic [31:0] give_up_count;
      logic [31:0] longest_recovery;
      logic [47:0] normal_total_time;
      logic [47:0] recovery_total_time;
   } frs_result_type;

endpackage

[rtl/frs_ifs.sv]
interface frs_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] gravity_z;
   logic signed [15:0] gyro_x;
   logic signed [15:0] gyro_y;
   logic signed [15:0] gyro_z;
   logic [15:0]        tick_time;

   modport source (
      output valid, gravity_z, gyro_x, gyro_y, gyro_z, tick_time,
      input  ready
   );
   modport sink (
      input  valid, gravity_z, gyro_x, gyro_y, gyro_z, tick_time,
      output ready
   );
endinterface

interface frs_rsp_if;
   logic        valid;
   logic        ready;
   logic        active_driver;
   logic        handed_off;
   logic        handed_back;
   logic [31:0] rescue_count;
   logic [31:0] stuck_rescue_count;
   logic [31:0] give_up_count;
   logic [31:0] longest_recovery;
   logic [47:0] normal_total_time;
   logic [47:0] recovery_total_time;

   modport source (
      output valid, active_driver, handed_off, handed_back, rescue_count,
             stuck_rescue_count, give_up_count, longest_recovery,
             normal_total_time, recovery_total_time,
      input  ready
   );
   modport sink (
      input  valid, active_driver, handed_off, handed_back, rescue_count,
             stuck_rescue_count, give_up_count, longest_recovery,
             normal_total_time, recovery_total_time,
      output ready
   );
endinterface

[rtl/fall_recovery_supervisor.sv]
// Channel   Direction  Handshake            Payload
// req_chan  in         valid/ready          gravity_z, gyro_x/y/z, tick_time
// rsp_chan  out        valid/ready          driver, hand flags, counters, totals
// csr_*     in         csr_we (no ready)    csr_index, csr_wdata
//
// One transaction per cycle sustained while rsp_chan.ready holds; a request is
// captured in the input register when accepted, then the mode update and the
// result register take it, and the result is offered from the result register.
// The mode and timer update is a set of saturating adds and compares per tick.
// Reset is synchronous, active high, and clears mode, timers, totals, counters.
// A stalled result holds in the output register while one more request waits
// in the input register; requests stop only when both are full.
module fall_recovery_supervisor (
   input  logic                            clock,
   input  logic                            reset,
   frs_req_if.sink                         req_chan,
   frs_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [frs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [frs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import frs_pkg::*;

   frs_cfg_type    cfg;
   frs_sample_type sample;
   frs_result_type result;
   logic           sample_valid;
   logic           advance;
   logic           rsp_valid_ff, rsp_valid_in;
   frs_result_type rsp_data_ff;

   frs_cfg_regs u_cfg_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   frs_sample_reg u_sample_reg (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .advance      (advance),
      .sample_valid (sample_valid),
      .sample       (sample)
   );

   frs_mode_core u_mode_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .sample  (sample),
      .advance (advance),
      .result  (result)
   );

   // Move the held transaction when the output register is free or draining
   assign advance = sample_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.active_driver       = rsp_data_ff.active_driver;
   assign rsp_chan.handed_off          = rsp_data_ff.handed_off;
   assign rsp_chan.handed_back         = rsp_data_ff.handed_back;
   assign rsp_chan.rescue_count        = rsp_data_ff.rescue_count;
   assign rsp_chan.stuck_rescue_count  = rsp_data_ff.stuck_rescue_count;
   assign rsp_chan.give_up_count       = rsp_data_ff.give_up_count;
   assign rsp_chan.longest_recovery    = rsp_data_ff.longest_recovery;
   assign rsp_chan.normal_total_time   = rsp_data_ff.normal_total_time;
   assign rsp_chan.recovery_total_time = rsp_data_ff.recovery_total_time;

endmodule

[rtl/frs_cfg_regs.sv]
module frs_cfg_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [frs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [frs_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output frs_pkg::frs_cfg_type                 cfg
);
   import frs_pkg::*;

   frs_cfg_type cfg_ff;
   frs_cfg_type cfg_in;

   // Decode the register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (frs_csr_index_type'(csr_index))
            CSR_FALLEN_GRAVITY_LIMIT:  cfg_in.fallen_gravity_limit  = csr_wdata[15:0];
            CSR_FALLEN_DEBOUNCE_TIME:  cfg_in.fallen_debounce_time  = csr_wdata[31:0];
            CSR_STUCK_TIME:            cfg_in.stuck_time            = csr_wdata[31:0];
            CSR_STUCK_GRAVITY_LIMIT:   cfg_in.stuck_gravity_limit   = csr_wdata[15:0];
            CSR_UPRIGHT_GRAVITY_LIMIT: cfg_in.upright_gravity_limit = csr_wdata[15:0];
            CSR_UPRIGHT_HOLD_TIME:     cfg_in.upright_hold_time     = csr_wdata[31:0];
            CSR_STILL_GYRO_LIMIT:      cfg_in.still_gyro_limit      = csr_wdata[15:0];
            CSR_GIVE_UP_TIME:          cfg_in.give_up_time          = csr_wdata[31:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers, load reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fallen_gravity_limit  <= FALLEN_GRAVITY_LIMIT_RST;
         cfg_ff.fallen_debounce_time  <= FALLEN_DEBOUNCE_TIME_RST;
         cfg_ff.stuck_time            <= STUCK_TIME_RST;
         cfg_ff.stuck_gravity_limit   <= STUCK_GRAVITY_LIMIT_RST;
         cfg_ff.upright_gravity_limit <= UPRIGHT_GRAVITY_LIMIT_RST;
         cfg_ff.upright_hold_time     <= UPRIGHT_HOLD_TIME_RST;
         cfg_ff.still_gyro_limit      <= STILL_GYRO_LIMIT_RST;
         cfg_ff.give_up_time          <= GIVE_UP_TIME_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/frs_sample_reg.sv]
module frs_sample_reg (
   input  logic                    clock,
   input  logic                    reset,
   frs_req_if.sink                 req_chan,
   input  logic                    advance,
   output logic                    sample_valid,
   output frs_pkg::frs_sample_type sample
);
   import frs_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   frs_sample_type sample_ff;
   logic           take;

   // Accept while empty or while the held transaction moves on
   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the payload; no reset needed
   always_ff @(posedge clock) begin
      if (take) begin
         sample_ff.gravity_z <= req_chan.gravity_z;
         sample_ff.gyro_x    <= req_chan.gyro_x;
         sample_ff.gyro_y    <= req_chan.gyro_y;
         sample_ff.gyro_z    <= req_chan.gyro_z;
         sample_ff.tick_time <= req_chan.tick_time;
      end
   end

   assign sample_valid = valid_ff;
   assign sample       = sample_ff;

endmodule

[rtl/frs_mode_core.sv]
module frs_mode_core (
   input  logic                    clock,
   input  logic                    reset,
   input  frs_pkg::frs_cfg_type    cfg,
   input  frs_pkg::frs_sample_type sample,
   input  logic                    advance,
   output frs_pkg::frs_result_type result
);
   import frs_pkg::*;

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[32] ? {32{1'b1}} : s[31:0];
   endfunction

   function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [15:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {33'd0, b};
      return s[48] ? {48{1'b1}} : s[47:0];
   endfunction

   function automatic logic [31:0] sat_inc32(input logic [31:0] a);
      return (a == {32{1'b1}}) ? a : a + 32'd1;
   endfunction

   function automatic logic [16:0] mag17(input logic signed [15:0] v);
      logic [16:0] e;
      e = {v[15], v};
      return v[15] ? 17'(-e) : e;
   endfunction

   frs_mode_type mode_ff, mode_in;
   logic [31:0]  fallen_ff, fallen_in;
   logic [31:0]  stuck_ff, stuck_in;
   logic [31:0]  upright_ff, upright_in;
   logic [31:0]  episode_ff, episode_in;
   logic [47:0]  normal_tot_ff, normal_tot_in;
   logic [47:0]  recovery_tot_ff, recovery_tot_in;
   logic [31:0]  rescues_ff, rescues_in;
   logic [31:0]  stuck_rescues_ff, stuck_rescues_in;
   logic [31:0]  give_ups_ff, give_ups_in;
   logic [31:0]  longest_ff, longest_in;

   logic [16:0] mag_x, mag_y, mag_z, gyro_max;
   logic [31:0] fallen_next, stuck_next, upright_next, episode_sum, hold_time;
   logic        stuck_on, stuck_hit, fall_hit;
   logic        still_mode, upright_ok, recovered, exhausted;
   logic        hand_off, hand_back;

   // Evaluate the tests for this tick
   always_comb begin
      mag_x    = mag17(sample.gyro_x);
      mag_y    = mag17(sample.gyro_y);
      mag_z    = mag17(sample.gyro_z);
      gyro_max = mag_x;
      if (mag_y > gyro_max) gyro_max = mag_y;
      if (mag_z > gyro_max) gyro_max = mag_z;

      fallen_next = (sample.gravity_z > cfg.fallen_gravity_limit)
                    ? sat_add32(fallen_ff, sample.tick_time) : 32'd0;
      stuck_on    = (cfg.stuck_time != 32'd0);
      stuck_next  = (stuck_on && (sample.gravity_z > cfg.stuck_gravity_limit))
                    ? sat_add32(stuck_ff, sample.tick_time) : 32'd0;
      stuck_hit   = stuck_on && (stuck_next >= cfg.stuck_time);
      fall_hit    = (fallen_next >= cfg.fallen_debounce_time);

      still_mode   = (cfg.still_gyro_limit != 16'd0);
      upright_ok   = still_mode
                     ? ((sample.gravity_z < STILL_GRAVITY_LIMIT)
                        && (gyro_max < {1'b0, cfg.still_gyro_limit}))
                     : (sample.gravity_z < cfg.upright_gravity_limit);
      upright_next = upright_ok ? sat_add32(upright_ff, sample.tick_time) : 32'd0;
      hold_time    = still_mode ? STILL_HOLD_US : cfg.upright_hold_time;
      recovered    = (upright_next >= hold_time);
      episode_sum  = sat_add32(episode_ff, sample.tick_time);
      exhausted    = (episode_sum >= cfg.give_up_time);
   end

   // Next driver mode
   always_comb begin
      unique case (mode_ff)
         MODE_NORMAL:   mode_in = (fall_hit || stuck_hit) ? MODE_RECOVERY : MODE_NORMAL;
         MODE_RECOVERY: mode_in = (recovered || exhausted) ? MODE_NORMAL : MODE_RECOVERY;
         default:       mode_in = MODE_NORMAL;
      endcase
   end

   // Timers, totals and counters per mode
   always_comb begin
      fallen_in        = fallen_ff;
      stuck_in         = stuck_ff;
      upright_in       = upright_ff;
      episode_in       = episode_ff;
      normal_tot_in    = normal_tot_ff;
      recovery_tot_in  = recovery_tot_ff;
      rescues_in       = rescues_ff;
      stuck_rescues_in = stuck_rescues_ff;
      give_ups_in      = give_ups_ff;
      longest_in       = longest_ff;
      hand_off         = 1'b0;
      hand_back        = 1'b0;
      unique case (mode_ff)
         MODE_NORMAL: begin
            normal_tot_in = sat_add48(normal_tot_ff, sample.tick_time);
            fallen_in     = fallen_next;
            stuck_in      = stuck_next;
            if (stuck_hit) stuck_rescues_in = sat_inc32(stuck_rescues_ff);
            if (fall_hit || stuck_hit) begin
               hand_off   = 1'b1;
               fallen_in  = 32'd0;
               stuck_in   = 32'd0;
               upright_in = 32'd0;
               episode_in = 32'd0;
               rescues_in = sat_inc32(rescues_ff);
            end
         end
         MODE_RECOVERY: begin
            recovery_tot_in = sat_add48(recovery_tot_ff, sample.tick_time);
            episode_in      = episode_sum;
            upright_in      = upright_next;
            if (recovered || exhausted) begin
               hand_back = 1'b1;
               if (episode_sum > longest_ff) longest_in = episode_sum;
               if (exhausted && !recovered) give_ups_in = sat_inc32(give_ups_ff);
               upright_in = 32'd0;
               fallen_in  = 32'd0;
            end
         end
         default: begin
            hand_off  = 1'b0;
            hand_back = 1'b0;
         end
      endcase
   end

   // Advance the state once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_NORMAL;
         fallen_ff        <= '0;
         stuck_ff         <= '0;
         upright_ff       <= '0;
         episode_ff       <= '0;
         normal_tot_ff    <= '0;
         recovery_tot_ff  <= '0;
         rescues_ff       <= '0;
         stuck_rescues_ff <= '0;
         give_ups_ff      <= '0;
         longest_ff       <= '0;
      end else if (advance) begin
         mode_ff          <= mode_in;
         fallen_ff        <= fallen_in;
         stuck_ff         <= stuck_in;
         upright_ff       <= upright_in;
         episode_ff       <= episode_in;
         normal_tot_ff    <= normal_tot_in;
         recovery_tot_ff  <= recovery_tot_in;
         rescues_ff       <= rescues_in;
         stuck_rescues_ff <= stuck_rescues_in;
         give_ups_ff      <= give_ups_in;
         longest_ff       <= longest_in;
      end
   end

   assign result.active_driver       = (mode_in == MODE_RECOVERY);
   assign result.handed_off          = hand_off;
   assign result.handed_back         = hand_back;
   assign result.rescue_count        = rescues_in;
   assign result.stuck_rescue_count  = stuck_rescues_in;
   assign result.give_up_count       = give_ups_in;
   assign result.longest_recovery    = longest_in;
   assign result.normal_total_time   = normal_tot_in;
   assign result.recovery_total_time = recovery_tot_in;

   // A hand-off starts a fresh episode in recovery mode
   a_handoff_enters_recovery: assert property (@(posedge clock) disable iff (reset)
      advance && hand_off |=> mode_ff == MODE_RECOVERY && episode_ff == 32'd0)
      else $error("hand-off did not enter recovery with a cleared episode");

   // Without a transaction the state holds
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(mode_ff) && $stable(rescues_ff) && $stable(normal_tot_ff))
      else $error("state changed without a transaction");

   // The rescue counter never goes backward
   a_rescues_monotonic: assert property (@(posedge clock) disable iff (reset)
      advance |=> rescues_ff >= $past(rescues_ff))
      else $error("rescue counter decreased");

   // A hand-back returns to normal with the upright timer cleared
   a_handback_enters_normal: assert property (@(posedge clock) disable iff (reset)
      advance && hand_back |=> mode_ff == MODE_NORMAL && upright_ff == 32'd0)
      else $error("hand-back did not return to normal");

endmodule
